// File: rtl/core/est_pkg.sv
// ----------------------------------------------------------------------------
// est_pkg
// Types, codes and the exposure table shared by the exposure sweep tuner.
// ----------------------------------------------------------------------------
package est_pkg;

  localparam int unsigned LVL_W       = 5;
  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned SCORE_W     = 16;
  localparam int unsigned EXPO_W      = 16;
  localparam int unsigned SET_W       = 13;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned MEAN_W      = 16;
  localparam int unsigned REACH_W     = 5;
  localparam int unsigned RATIO_W     = 4;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  // Exposure times per level; levels past the listed ones read zero
  localparam logic [SET_W-1:0] EXP_TABLE [TABLE_DEPTH] = '{
    13'd12,   13'd25,   13'd30,   13'd35,   13'd50,   13'd100,  13'd150,  13'd200,
    13'd250,  13'd300,  13'd400,  13'd500,  13'd1000, 13'd2000, 13'd4000, 13'd6000,
    13'd8000, 13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,
    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0
  };

  typedef enum logic [KIND_W-1:0] {
    KIND_TRIAL  = 2'd0,
    KIND_CHOSEN = 2'd1,
    KIND_MEAN   = 2'd2
  } est_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAUSE  = 2'd0,
    CFG_SETTLE = 2'd1,
    CFG_REACH  = 2'd2,
    CFG_RATIO  = 2'd3
  } est_cfg_idx_e;

  typedef enum logic [3:0] {
    PH_MON_PAUSE     = 4'b0001,
    PH_MON_COLLECT   = 4'b0010,
    PH_TRIAL_SETTLE  = 4'b0100,
    PH_TRIAL_COLLECT = 4'b1000
  } est_phase_e;

  typedef struct packed {
    logic [CNT_W-1:0]   pause_samples;
    logic [CNT_W-1:0]   settle_samples;
    logic [REACH_W-1:0] window_reach;
    logic [RATIO_W-1:0] retune_ratio_tenths;
  } est_cfg_t;

endpackage

// File: rtl/core/exposure_sweep_tuner.sv
// ----------------------------------------------------------------------------
// exposure_sweep_tuner
// Keeps a camera exposure level tuned from per-frame sharpness scores,
// sweeping nearby table levels when the windowed mean drops.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                | payload
//   ---------+--------------------------+------------------------------------
//   in       | in_valid_i / in_ready_o  | action_i, blurriness_i,
//            |                          | reported_exposure_i
//   out      | out_valid_o / out_ready_i| kind_o, exposure_setting_o,
//            |                          | mean_blurriness_o
//   cfg      | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
// One item per cycle is accepted unless a result item waits on a full result
// register; a result goes through the input register, state update into the
// result register and mean multiply into the output register.
// Reset clears the handshake state and tuning state; the configuration
// registers take their defaults. No clearing pass is needed.
// A stalled output holds its item while two more stages keep filling;
// items without a result flow until a result item waits in the input stage.
// ----------------------------------------------------------------------------
module exposure_sweep_tuner #(
  parameter int unsigned LEVELS         = 17,
  parameter int unsigned WINDOW_SAMPLES = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [est_pkg::SCORE_W-1:0]   blurriness_i,
  input  logic [est_pkg::EXPO_W-1:0]    reported_exposure_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [est_pkg::KIND_W-1:0]    kind_o,
  output logic [est_pkg::SET_W-1:0]     exposure_setting_o,
  output logic [est_pkg::MEAN_W-1:0]    mean_blurriness_o,
  input  logic                          cfg_we_i,
  input  logic [est_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [est_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import est_pkg::*;

  localparam int unsigned SUM_W = $clog2(WINDOW_SAMPLES * 65535 + 1);

  est_cfg_t           cfg_q;
  logic               res_valid;
  logic               res_ready;
  est_kind_e          res_kind;
  logic [SET_W-1:0]   res_setting;
  logic [SUM_W-1:0]   res_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pause_samples       <= 16'd1500;
      cfg_q.settle_samples      <= 16'd1000;
      cfg_q.window_reach        <= 5'd2;
      cfg_q.retune_ratio_tenths <= 4'd9;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PAUSE:  cfg_q.pause_samples       <= cfg_wdata_i;
        CFG_SETTLE: cfg_q.settle_samples      <= cfg_wdata_i;
        CFG_REACH:  cfg_q.window_reach        <= cfg_wdata_i[REACH_W-1:0];
        CFG_RATIO:  cfg_q.retune_ratio_tenths <= cfg_wdata_i[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  est_core #(
    .LEVELS         (LEVELS),
    .WINDOW_SAMPLES (WINDOW_SAMPLES),
    .SUM_W          (SUM_W)
  ) u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .action_i            (action_i),
    .blurriness_i        (blurriness_i),
    .reported_exposure_i (reported_exposure_i),
    .res_valid_o         (res_valid),
    .res_ready_i         (res_ready),
    .res_kind_o          (res_kind),
    .res_setting_o       (res_setting),
    .res_sum_o           (res_sum)
  );

  est_mean #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES),
    .SUM_W          (SUM_W)
  ) u_mean (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .res_valid_i        (res_valid),
    .res_ready_o        (res_ready),
    .res_kind_i         (res_kind),
    .res_setting_i      (res_setting),
    .res_sum_i          (res_sum),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .kind_o             (kind_o),
    .exposure_setting_o (exposure_setting_o),
    .mean_blurriness_o  (mean_blurriness_o)
  );

endmodule

// File: rtl/core/est_core.sv
// ----------------------------------------------------------------------------
// est_core
// Input register, tuning state and result register of the exposure tuner.
// One item is processed per cycle unless its result finds the register full.
// ----------------------------------------------------------------------------
module est_core #(
  parameter int unsigned LEVELS         = 17,
  parameter int unsigned WINDOW_SAMPLES = 30,
  parameter int unsigned SUM_W          = 21
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  est_pkg::est_cfg_t             cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [est_pkg::SCORE_W-1:0]   blurriness_i,
  input  logic [est_pkg::EXPO_W-1:0]    reported_exposure_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output est_pkg::est_kind_e            res_kind_o,
  output logic [est_pkg::SET_W-1:0]     res_setting_o,
  output logic [SUM_W-1:0]              res_sum_o
);
  import est_pkg::*;

  localparam int unsigned RAT_W = SUM_W + 4;
  localparam int unsigned LVL_EXT_W = LVL_W + 1;

  function automatic logic [SET_W-1:0] table_at(input logic [LVL_W-1:0] lvl);
    logic [SET_W-1:0] val;
    val = '0;
    if ({1'b0, lvl} < LVL_EXT_W'(LEVELS)) begin
      val = EXP_TABLE[lvl];
    end
    return val;
  endfunction

  // input register
  logic                in_v_q;
  logic                in_action_q;
  logic [SCORE_W-1:0]  in_score_q;
  logic [EXPO_W-1:0]   in_rep_q;

  // tuning state
  est_phase_e          phase_q, phase_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SUM_W-1:0]    win_q, win_d;
  logic [SUM_W-1:0]    tuned_q, tuned_d;
  logic [SUM_W-1:0]    best_sum_q, best_sum_d;
  logic [LVL_W-1:0]    best_lvl_q, best_lvl_d;
  logic [LVL_W-1:0]    trial_q, trial_d;
  logic [LVL_W-1:0]    upper_q, upper_d;
  logic [LVL_W-1:0]    cur_q, cur_d;

  // result register
  logic                res_v_q;
  est_kind_e           res_kind_q;
  logic [SET_W-1:0]    res_setting_q;
  logic [SUM_W-1:0]    res_sum_q;

  logic                pausing;
  logic [CNT_W-1:0]    limit;
  est_phase_e          coll_phase;
  logic [SUM_W-1:0]    base_sum;
  logic [CNT_W-1:0]    base_cnt;
  logic [SUM_W-1:0]    sum_new;
  logic [CNT_W-1:0]    cnt_new;
  logic [RAT_W-1:0]    sum_x10;
  logic [RAT_W-1:0]    thr;
  logic                retune;
  logic [LVL_W-1:0]    lo_lvl;
  logic [LVL_W-1:0]    hi_lvl;
  logic [LVL_EXT_W-1:0] hi_ext;
  logic                better;
  logic [SUM_W-1:0]    nb_sum;
  logic [LVL_W-1:0]    nb_lvl;
  logic [LVL_W-1:0]    match_lvl;
  logic                emit;
  est_kind_e           e_kind;
  logic [LVL_W-1:0]    e_lvl;
  logic [SUM_W-1:0]    e_sum;
  logic                res_free;
  logic                fire;

  assign pausing    = (phase_q == PH_MON_PAUSE) || (phase_q == PH_TRIAL_SETTLE);
  assign limit      = (phase_q == PH_MON_PAUSE) ? cfg_i.pause_samples : cfg_i.settle_samples;
  assign coll_phase = ((phase_q == PH_MON_PAUSE) || (phase_q == PH_MON_COLLECT)) ?
                      PH_MON_COLLECT : PH_TRIAL_COLLECT;
  // leaving a pause starts a fresh window
  assign base_sum   = pausing ? '0 : win_q;
  assign base_cnt   = pausing ? '0 : cnt_q;
  assign sum_new    = base_sum + SUM_W'(in_score_q);
  assign cnt_new    = base_cnt + CNT_W'(1);

  assign sum_x10 = RAT_W'({sum_new, 3'b000}) + RAT_W'({sum_new, 1'b0});
  assign thr     = RAT_W'(cfg_i.retune_ratio_tenths) * RAT_W'(tuned_q);
  assign retune  = (tuned_q == '0) || (sum_x10 < thr);

  assign lo_lvl = (cur_q > cfg_i.window_reach) ? (cur_q - cfg_i.window_reach) : '0;
  assign hi_ext = {1'b0, cur_q} + {1'b0, cfg_i.window_reach};
  assign hi_lvl = (hi_ext > LVL_EXT_W'(LEVELS - 1)) ? LVL_W'(LEVELS - 1) : hi_ext[LVL_W-1:0];

  assign better = sum_new > best_sum_q;
  assign nb_sum = better ? sum_new : best_sum_q;
  assign nb_lvl = better ? trial_q : best_lvl_q;

  // first level whose exposure equals the report, level 0 when none does
  always_comb begin
    match_lvl = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if ((i < int'(LEVELS)) && ({3'b000, EXP_TABLE[i]} == in_rep_q)) begin
        match_lvl = LVL_W'(i);
      end
    end
  end

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    win_d      = win_q;
    tuned_d    = tuned_q;
    best_sum_d = best_sum_q;
    best_lvl_d = best_lvl_q;
    trial_d    = trial_q;
    upper_d    = upper_q;
    cur_d      = cur_q;
    emit       = 1'b0;
    e_kind     = KIND_MEAN;
    e_lvl      = '0;
    e_sum      = '0;
    if (in_action_q) begin
      cur_d = match_lvl;
    end else if (pausing && (cnt_q < limit)) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cnt_new < CNT_W'(WINDOW_SAMPLES)) begin
      win_d   = sum_new;
      cnt_d   = cnt_new;
      phase_d = coll_phase;
    end else if (coll_phase == PH_MON_COLLECT) begin
      emit  = 1'b1;
      cnt_d = '0;
      win_d = '0;
      if (retune) begin
        upper_d    = hi_lvl;
        best_sum_d = '0;
        best_lvl_d = '0;
        trial_d    = lo_lvl;
        cur_d      = lo_lvl;
        phase_d    = PH_TRIAL_SETTLE;
        e_kind     = KIND_TRIAL;
        e_lvl      = lo_lvl;
      end else begin
        phase_d = PH_MON_PAUSE;
        e_kind  = KIND_MEAN;
        e_sum   = sum_new;
      end
    end else begin
      emit       = 1'b1;
      cnt_d      = '0;
      win_d      = '0;
      best_sum_d = nb_sum;
      best_lvl_d = nb_lvl;
      if (trial_q < upper_q) begin
        trial_d = trial_q + LVL_W'(1);
        cur_d   = trial_q + LVL_W'(1);
        phase_d = PH_TRIAL_SETTLE;
        e_kind  = KIND_TRIAL;
        e_lvl   = trial_q + LVL_W'(1);
      end else begin
        cur_d   = nb_lvl;
        tuned_d = nb_sum;
        phase_d = PH_MON_PAUSE;
        e_kind  = KIND_CHOSEN;
        e_lvl   = nb_lvl;
        e_sum   = nb_sum;
      end
    end
  end

  assign res_free   = !res_v_q || res_ready_i;
  // an item that yields no result never waits on the result register
  assign fire       = in_v_q && (!emit || res_free);
  assign in_ready_o = !in_v_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q     <= 1'b0;
      res_v_q    <= 1'b0;
      phase_q    <= PH_MON_COLLECT;
      cnt_q      <= '0;
      win_q      <= '0;
      tuned_q    <= '0;
      best_sum_q <= '0;
      best_lvl_q <= '0;
      trial_q    <= '0;
      upper_q    <= '0;
      cur_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (fire) begin
        phase_q    <= phase_d;
        cnt_q      <= cnt_d;
        win_q      <= win_d;
        tuned_q    <= tuned_d;
        best_sum_q <= best_sum_d;
        best_lvl_q <= best_lvl_d;
        trial_q    <= trial_d;
        upper_q    <= upper_d;
        cur_q      <= cur_d;
      end
      if (res_free) begin
        res_v_q <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_action_q <= action_i;
      in_score_q  <= blurriness_i;
      in_rep_q    <= reported_exposure_i;
    end
    if (fire && emit) begin
      res_kind_q    <= e_kind;
      res_setting_q <= (e_kind == KIND_MEAN) ? '0 : table_at(e_lvl);
      res_sum_q     <= e_sum;
    end
  end

  assign res_valid_o   = res_v_q;
  assign res_kind_o    = res_kind_q;
  assign res_setting_o = res_setting_q;
  assign res_sum_o     = res_sum_q;

endmodule

// File: rtl/core/est_mean.sv
// ----------------------------------------------------------------------------
// est_mean
// Output stage: turns a window sum into its truncated mean by a reciprocal
// multiply and holds the finished item for the consumer.
// ----------------------------------------------------------------------------
module est_mean #(
  parameter int unsigned WINDOW_SAMPLES = 30,
  parameter int unsigned SUM_W          = 21
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          res_valid_i,
  output logic                          res_ready_o,
  input  est_pkg::est_kind_e            res_kind_i,
  input  logic [est_pkg::SET_W-1:0]     res_setting_i,
  input  logic [SUM_W-1:0]              res_sum_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [est_pkg::KIND_W-1:0]    kind_o,
  output logic [est_pkg::SET_W-1:0]     exposure_setting_o,
  output logic [est_pkg::MEAN_W-1:0]    mean_blurriness_o
);
  import est_pkg::*;

  // ceil(2^S / N) with S = SUM_W + ceil(log2 N) gives the exact floor
  // quotient for every sum below 2^SUM_W
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(WINDOW_SAMPLES);
  localparam int unsigned MUL_W     = SUM_W + 2;
  localparam int unsigned PROD_W    = SUM_W + MUL_W;
  localparam logic [63:0] DIV_MUL_FULL =
    ((64'd1 << DIV_SHIFT) + 64'(WINDOW_SAMPLES) - 64'd1) / 64'(WINDOW_SAMPLES);
  localparam logic [MUL_W-1:0] DIV_MUL = DIV_MUL_FULL[MUL_W-1:0];

  logic [PROD_W-1:0]  prod;
  logic               out_v_q;
  est_kind_e          kind_q;
  logic [SET_W-1:0]   setting_q;
  logic [MEAN_W-1:0]  mean_q;

  assign prod        = {{MUL_W{1'b0}}, res_sum_i} * {{SUM_W{1'b0}}, DIV_MUL};
  assign res_ready_o = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res_ready_o) begin
      out_v_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      kind_q    <= res_kind_i;
      setting_q <= res_setting_i;
      mean_q    <= prod[DIV_SHIFT +: MEAN_W];
    end
  end

  assign out_valid_o        = out_v_q;
  assign kind_o             = kind_q;
  assign exposure_setting_o = setting_q;
  assign mean_blurriness_o  = mean_q;

endmodule

// File: rtl/core/est_checker.sv
// ----------------------------------------------------------------------------
// est_checker
// Port-level checks on the result channel of the exposure tuner.
// ----------------------------------------------------------------------------
module est_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [est_pkg::KIND_W-1:0]  kind_i,
  input  logic [est_pkg::SET_W-1:0]   exposure_setting_i,
  input  logic [est_pkg::MEAN_W-1:0]  mean_blurriness_i
);
  import est_pkg::*;

  // a trial setting carries no mean
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (kind_i == KIND_TRIAL)) |-> (mean_blurriness_i == '0))
    else $error("trial item with non-zero mean");

  // a plain monitor report carries no setting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (kind_i == KIND_MEAN)) |-> (exposure_setting_i == '0))
    else $error("monitor item with non-zero setting");

  // settings come from the table only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (exposure_setting_i <= 13'd8000))
    else $error("setting beyond the exposure table");

  // hold a stalled item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(kind_i) && $stable(exposure_setting_i)
       && $stable(mean_blurriness_i)))
    else $error("stalled result item changed");

endmodule

bind exposure_sweep_tuner est_checker u_est_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .kind_i             (kind_o),
  .exposure_setting_i (exposure_setting_o),
  .mean_blurriness_i  (mean_blurriness_o)
);

// File: sim/tb_exposure_sweep_tuner.sv
// ----------------------------------------------------------------------------
// tb_exposure_sweep_tuner
// Self-checking bench for the exposure sweep tuner. A directed table walks
// the sweep, tie, no-winner, mid-sweep report and unmatched report cases,
// then random frame streams run under several register settings. Every
// accepted item goes through an in-bench tuner model; results are checked
// in order, field by field, under random back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_exposure_sweep_tuner;
  import est_pkg::*;

  localparam int unsigned N_LEVELS    = 17;
  localparam int unsigned WIN         = 30;
  localparam int unsigned DRAIN       = 6;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic [12:0] EXPO_LEVELS [32] = '{
    13'd12,   13'd25,   13'd30,   13'd35,   13'd50,   13'd100,  13'd150,  13'd200,
    13'd250,  13'd300,  13'd400,  13'd500,  13'd1000, 13'd2000, 13'd4000, 13'd6000,
    13'd8000, 13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,
    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0
  };

  typedef struct packed {
    logic        act;
    logic [15:0] blur;
    logic [15:0] rep;
  } frame_item_t;

  typedef struct packed {
    est_kind_e   kind;
    logic [12:0] setting;
    logic [15:0] mean;
  } tuner_result_t;

  typedef struct packed {
    logic        act;
    logic [15:0] blur;
    logic [15:0] rep;
    logic [7:0]  reps;
    logic        typed;
    est_kind_e   kind;
    logic [12:0] setting;
    logic [15:0] mean;
  } dir_row_t;

  // Runs of identical items; the typed result belongs to the last item of a run
  localparam int unsigned N_ROWS = 17;
  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    '{1'b1, 16'h0000, 16'd35,   8'd1,  1'b0, KIND_TRIAL,  13'd0,    16'd0},
    '{1'b0, 16'hFFFF, 16'h0000, 8'd30, 1'b1, KIND_TRIAL,  13'd30,   16'd0},
    '{1'b0, 16'h0000, 16'h0000, 8'd30, 1'b1, KIND_TRIAL,  13'd35,   16'd0},
    '{1'b0, 16'hFFFF, 16'h0000, 8'd15, 1'b0, KIND_TRIAL,  13'd0,    16'd0},
    '{1'b1, 16'h0000, 16'd12,   8'd1,  1'b0, KIND_TRIAL,  13'd0,    16'd0},
    '{1'b0, 16'hFFFF, 16'h0000, 8'd15, 1'b1, KIND_TRIAL,  13'd50,   16'd0},
    '{1'b0, 16'hFFFF, 16'h0000, 8'd30, 1'b1, KIND_CHOSEN, 13'd35,   16'd65535},
    '{1'b1, 16'h0000, 16'hFFFF, 8'd1,  1'b0, KIND_TRIAL,  13'd0,    16'd0},
    '{1'b1, 16'h0000, 16'd8000, 8'd1,  1'b0, KIND_TRIAL,  13'd0,    16'd0},
    '{1'b0, 16'hFFFF, 16'h0000, 8'd30, 1'b1, KIND_MEAN,   13'd0,    16'd65535},
    '{1'b0, 16'h0000, 16'h0000, 8'd30, 1'b1, KIND_TRIAL,  13'd6000, 16'd0},
    '{1'b0, 16'h0000, 16'h0000, 8'd30, 1'b1, KIND_TRIAL,  13'd8000, 16'd0},
    '{1'b0, 16'h0000, 16'h0000, 8'd30, 1'b1, KIND_CHOSEN, 13'd12,   16'd0},
    '{1'b0, 16'h1234, 16'h0000, 8'd30, 1'b0, KIND_TRIAL,  13'd0,    16'd0},
    '{1'b0, 16'h8000, 16'h0000, 8'd30, 1'b0, KIND_TRIAL,  13'd0,    16'd0},
    '{1'b0, 16'h7FFF, 16'h0000, 8'd30, 1'b0, KIND_TRIAL,  13'd0,    16'd0},
    '{1'b1, 16'hFFFF, 16'd250,  8'd1,  1'b0, KIND_TRIAL,  13'd0,    16'd0}
  };

  logic         clk_i               = 1'b0;
  logic         rst_ni              = 1'b0;
  logic         in_valid_i          = 1'b0;
  logic         action_i            = 1'b0;
  logic [15:0]  blurriness_i        = '0;
  logic [15:0]  reported_exposure_i = '0;
  logic         out_ready_i         = 1'b0;
  logic         cfg_we_i            = 1'b0;
  est_cfg_idx_e cfg_index_i         = CFG_PAUSE;
  logic [15:0]  cfg_wdata_i         = '0;
  logic         in_ready_o;
  logic         out_valid_o;
  logic [1:0]   kind_o;
  logic [12:0]  exposure_setting_o;
  logic [15:0]  mean_blurriness_o;

  exposure_sweep_tuner uut (.*);

  always #5 clk_i = ~clk_i;

  // Tuner model state and registers
  est_phase_e  ph;
  logic [15:0] frames;
  logic [20:0] win_sum, tuned_sum, best_sum;
  logic [4:0]  best_lvl, trial_lvl, top_lvl, cur_lvl;
  logic [15:0] pause_len, settle_len;
  logic [4:0]  reach;
  logic [3:0]  ratio;

  tuner_result_t exp_q [$];
  int checked       = 0;
  int errors        = 0;
  int snd_idle_pct  = 15;
  int rcv_idle_pct  = 82;
  int hold_requests = 0;
  int holds_done    = 0;
  int unsigned hold_left = 0;
  int unsigned cycles    = 0;

  task automatic tuner_reset();
    pause_len  = 16'd1500;
    settle_len = 16'd1000;
    reach      = 5'd2;
    ratio      = 4'd9;
    ph         = PH_MON_COLLECT;
    frames     = '0;
    win_sum    = '0;
    tuned_sum  = '0;
    best_sum   = '0;
    best_lvl   = '0;
    trial_lvl  = '0;
    top_lvl    = '0;
    cur_lvl    = '0;
  endtask

  function automatic tuner_result_t open_trial(input logic [4:0] lvl);
    tuner_result_t r;
    trial_lvl = lvl;
    cur_lvl   = lvl;
    ph        = PH_TRIAL_SETTLE;
    frames    = '0;
    win_sum   = '0;
    r.kind    = KIND_TRIAL;
    r.setting = EXPO_LEVELS[lvl];
    r.mean    = '0;
    return r;
  endfunction

  function automatic bit tuner_step(input frame_item_t it, output tuner_result_t res);
    logic [5:0]  hi;
    logic [31:0] lhs, rhs;
    logic [15:0] lim;
    res = '{KIND_TRIAL, 13'd0, 16'd0};
    if (it.act) begin
      // first matching level wins, none matching gives level zero
      cur_lvl = '0;
      for (int i = N_LEVELS - 1; i >= 0; i--) begin
        if ({3'b000, EXPO_LEVELS[i]} == it.rep) cur_lvl = 5'(i);
      end
      return 1'b0;
    end
    if (ph == PH_MON_PAUSE || ph == PH_TRIAL_SETTLE) begin
      lim = (ph == PH_MON_PAUSE) ? pause_len : settle_len;
      if (frames < lim) begin
        frames++;
        return 1'b0;
      end
      if (ph == PH_MON_PAUSE) ph = PH_MON_COLLECT;
      else ph = PH_TRIAL_COLLECT;
      frames  = '0;
      win_sum = '0;
    end
    win_sum += it.blur;
    frames++;
    if (frames < WIN) return 1'b0;
    if (ph == PH_MON_COLLECT) begin
      lhs = 32'(win_sum) * 32'd10;
      rhs = 32'(ratio) * 32'(tuned_sum);
      if (tuned_sum == '0 || lhs < rhs) begin
        hi = 6'(cur_lvl) + 6'(reach);
        if (hi > 6'(N_LEVELS - 1)) hi = 6'(N_LEVELS - 1);
        top_lvl  = hi[4:0];
        best_sum = '0;
        best_lvl = '0;
        res = open_trial((cur_lvl > reach) ? cur_lvl - reach : 5'd0);
        return 1'b1;
      end
      res.kind    = KIND_MEAN;
      res.setting = '0;
      res.mean    = 16'(win_sum / WIN);
      ph      = PH_MON_PAUSE;
      frames  = '0;
      win_sum = '0;
      return 1'b1;
    end
    // strictly larger only, so ties keep the lower level
    if (win_sum > best_sum) begin
      best_sum = win_sum;
      best_lvl = trial_lvl;
    end
    if (trial_lvl < top_lvl) begin
      res = open_trial(trial_lvl + 5'd1);
      return 1'b1;
    end
    cur_lvl     = best_lvl;
    tuned_sum   = best_sum;
    res.kind    = KIND_CHOSEN;
    res.setting = EXPO_LEVELS[best_lvl];
    res.mean    = 16'(best_sum / WIN);
    ph      = PH_MON_PAUSE;
    frames  = '0;
    win_sum = '0;
    return 1'b1;
  endfunction

  task automatic put_reg(input est_cfg_idx_e idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] p, s, r, q);
    put_reg(CFG_PAUSE, p);
    put_reg(CFG_SETTLE, s);
    put_reg(CFG_REACH, r);
    put_reg(CFG_RATIO, q);
    cfg_we_i   <= 1'b0;
    pause_len  = p;
    settle_len = s;
    reach      = r[4:0];
    ratio      = q[3:0];
  endtask

  task automatic feed(input frame_item_t it, input bit typed, input tuner_result_t typed_res);
    tuner_result_t r;
    bit got;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    action_i            <= it.act;
    blurriness_i        <= it.blur;
    reported_exposure_i <= it.rep;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    got = tuner_step(it, r);
    if (typed) exp_q.push_back(typed_res);
    else if (got) exp_q.push_back(r);
  endtask

  // Hold the sender until every result is out and the pipeline has emptied
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (exp_q.size() > checked) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (holds_done != hold_requests) begin
      holds_done  <= holds_done + 1;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    tuner_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (checked >= exp_q.size()) begin
        $error("unexpected result: kind %0d setting %0d mean %0d",
               kind_o, exposure_setting_o, mean_blurriness_o);
        errors <= errors + 1;
      end else begin
        want = exp_q[checked];
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          errors <= errors + 1;
        end
        if (exposure_setting_o !== want.setting) begin
          $error("exposure_setting: expected %0d, got %0d", want.setting, exposure_setting_o);
          errors <= errors + 1;
        end
        if (mean_blurriness_o !== want.mean) begin
          $error("mean_blurriness: expected %0d, got %0d", want.mean, mean_blurriness_o);
          errors <= errors + 1;
        end
        checked <= checked + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_exposure_sweep_tuner: FAIL");
      $finish;
    end
  end

  initial begin
    frame_item_t   it;
    tuner_result_t typed_res;
    logic [15:0]   base;
    bit            exact;
    int            frames_left;
    int            n_items;
    tuner_reset();
    frames_left = 0;
    base        = '0;
    exact       = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    program_regs(16'd0, 16'd0, 16'd1, 16'd9);
    for (int r = 0; r < N_ROWS; r++) begin
      for (int k = 0; k < int'(DIR_ROWS[r].reps); k++) begin
        it        = '{DIR_ROWS[r].act, DIR_ROWS[r].blur, DIR_ROWS[r].rep};
        typed_res = '{DIR_ROWS[r].kind, DIR_ROWS[r].setting, DIR_ROWS[r].mean};
        feed(it, DIR_ROWS[r].typed && (k == int'(DIR_ROWS[r].reps) - 1), typed_res);
      end
    end

    for (int p = 0; p < 7; p++) begin
      wait_idle();
      if (p == 3) begin
        snd_idle_pct = 82;
        rcv_idle_pct = 15;
      end else if (p == 5) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      case (p)
        0: program_regs(16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                        16'd2, 16'd9);
        1: program_regs(16'hFFFF, 16'hFFFF, 16'($urandom) | 16'h001F,
                        16'($urandom) | 16'h000F);
        2: program_regs(16'h0000, 16'h0000, 16'($urandom) & 16'hFFE0,
                        16'($urandom) & 16'hFFF0);
        default: program_regs(16'($urandom_range(0, 10)), 16'($urandom_range(0, 10)),
                              {11'($urandom),
                               5'(($urandom_range(0, 7) == 0) ? $urandom_range(17, 31)
                                                              : $urandom_range(0, 16))},
                              {12'($urandom), 4'($urandom_range(0, 15))});
      endcase
      // long receiver stall with results arriving every window: block backs up
      if (p == 2) hold_requests++;
      n_items = (p == 2) ? 150 : 95;
      for (int k = 0; k < n_items; k++) begin
        if (frames_left == 0) begin
          case ($urandom_range(0, 9))
            0:       base = 16'h0000;
            1:       base = 16'hFFFF;
            default: base = 16'($urandom);
          endcase
          exact       = ($urandom_range(0, 3) == 0);
          frames_left = WIN;
        end
        it.act  = ($urandom_range(0, 99) < 4);
        it.blur = 16'($urandom);
        it.rep  = 16'($urandom);
        if (it.act) begin
          if ($urandom_range(0, 4) != 0)
            it.rep = {3'b000, EXPO_LEVELS[$urandom_range(0, N_LEVELS - 1)]};
        end else begin
          frames_left--;
          it.blur = exact ? base : base ^ 16'($urandom_range(0, 255));
        end
        feed(it, 1'b0, typed_res);
      end
    end

    wait_idle();
    if (errors == 0 && checked == exp_q.size()) begin
      $display("tb_exposure_sweep_tuner: PASS");
    end else begin
      $display("tb_exposure_sweep_tuner: FAIL");
    end
    $finish;
  end

endmodule
